// ===== rtl/mrex_pkg.sv =====
// mrex_pkg: beat types, opcode and function codes and constants shared by the
// R-type execute unit, its register file, its execute logic and its checker.
// No dependencies.
`default_nettype none

package mrex_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned NREGS     = 32;
    localparam int unsigned RIDX_W    = $clog2(NREGS);

    localparam logic [XLEN-1:0]   TEXT_BASE_RST = 32'h0040_0000;
    localparam logic [RIDX_W-1:0] SYSCALL_REG   = 5'd2;
    localparam logic [XLEN-1:0]   EXIT_CODE     = 32'd10;

    typedef enum logic [1:0] {
        OP_EXEC  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [XLEN-1:0]   instr_word;
        logic [RIDX_W-1:0] reg_index;
        logic [XLEN-1:0]   reg_value;
    } in_beat_t;

    typedef struct packed {
        logic [XLEN-1:0] read_data;
        logic            overflow;
        logic            unknown_function;
        logic            jump_valid;
        logic [XLEN-1:0] jump_target;
        logic            exit_request;
    } out_beat_t;

    // register file write back
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [XLEN-1:0]   data;
    } wb_t;

endpackage

`default_nettype wire

// ===== rtl/mrex_regfile.sv =====
// mrex_regfile: 32x32 register file in a synchronous memory with two read
// ports, per-entry valid bits for the all-zero reset, and same-edge forwarding.
// Depends on mrex_pkg.
`default_nettype none

module mrex_regfile
    import mrex_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [RIDX_W-1:0] ra_addr,
    input  wire logic [RIDX_W-1:0] rb_addr,
    input  wire wb_t               wb,
    output logic [XLEN-1:0]        a_data,
    output logic [XLEN-1:0]        b_data
);

    logic [XLEN-1:0]  mem [NREGS];
    logic [XLEN-1:0]  ra_data_reg, rb_data_reg, fwd_data_reg;
    logic [NREGS-1:0] valid_reg, valid_next;
    logic             a_vld_reg, b_vld_reg, a_fwd_reg, b_fwd_reg;

    always_ff @(posedge aclk) begin
        if (wb.en) begin
            mem[wb.addr] <= wb.data;
        end
        if (rd_en) begin
            ra_data_reg  <= mem[ra_addr];
            rb_data_reg  <= mem[rb_addr];
            fwd_data_reg <= wb.data;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (wb.en) begin
            valid_next[wb.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            a_fwd_reg <= 1'b0;
            b_fwd_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (rd_en) begin
                a_vld_reg <= valid_reg[ra_addr];
                b_vld_reg <= valid_reg[rb_addr];
                // memory returns old data when written on the read edge
                a_fwd_reg <= wb.en && (wb.addr == ra_addr);
                b_fwd_reg <= wb.en && (wb.addr == rb_addr);
            end
        end
    end

    assign a_data = a_fwd_reg ? fwd_data_reg : (a_vld_reg ? ra_data_reg : '0);
    assign b_data = b_fwd_reg ? fwd_data_reg : (b_vld_reg ? rb_data_reg : '0);

endmodule

`default_nettype wire

// ===== rtl/mrex_alu.sv =====
// mrex_alu: decodes the R-format word and executes one beat against the
// operands read from the register file; gives the result and the write back.
// Depends on mrex_pkg.
`default_nettype none

module mrex_alu
    import mrex_pkg::*;
(
    input  wire in_beat_t        beat,
    input  wire logic [XLEN-1:0] a_data,
    input  wire logic [XLEN-1:0] b_data,
    input  wire logic [XLEN-1:0] r2_data,
    input  wire logic [XLEN-1:0] text_base,
    output out_beat_t            res,
    output wb_t                  wb
);

    logic [5:0]        fn;
    logic [4:0]        shamt;
    logic [RIDX_W-1:0] rd;
    logic [XLEN-1:0]   sum, diff;
    logic              add_ovf, sub_ovf;

    assign fn    = beat.instr_word[5:0];
    assign shamt = beat.instr_word[10:6];
    assign rd    = beat.instr_word[15:11];
    assign sum   = a_data + b_data;
    assign diff  = a_data - b_data;

    assign add_ovf = ~(a_data[XLEN-1] ^ b_data[XLEN-1]) & (sum[XLEN-1] ^ a_data[XLEN-1]);
    assign sub_ovf = (a_data[XLEN-1] ^ b_data[XLEN-1]) & (diff[XLEN-1] ^ a_data[XLEN-1]);

    always_comb begin
        res     = '0;
        wb.en   = 1'b0;
        wb.addr = rd;
        wb.data = '0;
        unique case (opcode_t'(beat.opcode))
            OP_WRITE: begin
                wb.en   = 1'b1;
                wb.addr = beat.reg_index;
                wb.data = beat.reg_value;
            end
            OP_READ: begin
                res.read_data = a_data;
            end
            OP_EXEC: begin
                unique case (fn)
                    FN_ADD: begin
                        res.overflow = add_ovf;
                        wb.en        = ~add_ovf;
                        wb.data      = sum;
                    end
                    FN_ADDU: begin
                        wb.en   = 1'b1;
                        wb.data = sum;
                    end
                    FN_SUB: begin
                        res.overflow = sub_ovf;
                        wb.en        = ~sub_ovf;
                        wb.data      = diff;
                    end
                    FN_AND: begin
                        wb.en   = 1'b1;
                        wb.data = a_data & b_data;
                    end
                    FN_OR: begin
                        wb.en   = 1'b1;
                        wb.data = a_data | b_data;
                    end
                    FN_XOR: begin
                        wb.en   = 1'b1;
                        wb.data = a_data ^ b_data;
                    end
                    FN_SRL: begin
                        wb.en   = 1'b1;
                        wb.data = b_data >> shamt;
                    end
                    FN_SLL: begin
                        wb.en   = 1'b1;
                        wb.data = b_data << shamt;
                    end
                    FN_SYSCALL: begin
                        res.exit_request = (r2_data == EXIT_CODE);
                    end
                    FN_JR: begin
                        res.jump_valid  = 1'b1;
                        res.jump_target = a_data - text_base;
                    end
                    default: begin
                        res.unknown_function = 1'b1;
                    end
                endcase
            end
            default: begin
                res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mips_rtype_execute_unit_core.sv =====
// MIPS R-type execute unit: input beat -> register file read -> execute and
// write back into an output register. Depends on mrex_pkg, mrex_regfile, mrex_alu.
//
// Usage
//   s_ channel carries one beat per operation: execute an R-format word,
//   write a register or read a register. m_ channel returns one result beat
//   for every input beat, in order. cfg_wr_en/cfg_wr_data load text_base,
//   which is subtracted from the JR target; write it only while idle.
// Pipeline and throughput
//   An accepted beat passes the execute stage, then the output register on m_.
//   One beat per cycle is sustained while m_ready stays high: the register
//   file memory is read on the accept edge (two read ports, rs and rt) and
//   written when the beat leaves execute, with forwarding for a same-edge
//   write and read. Register 2 is mirrored in a flop for the SYSCALL exit test.
// Reset
//   aresetn low (synchronous) empties both stages, clears the per-entry
//   valid bits so every register reads as zero, and sets text_base to
//   0x00400000. No clearing pass is needed.
// Stall
//   With m_ready low the result holds in the output register, the execute
//   stage fills, and s_ready drops until m_ready returns.
`default_nettype none

module mips_rtype_execute_unit_core
    import mrex_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [XLEN-1:0] cfg_wr_data,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire in_beat_t        s_beat,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output out_beat_t            m_beat
);

    logic            s1_valid_reg;
    in_beat_t        s1_beat_reg;
    logic            m_valid_reg;
    out_beat_t       m_beat_reg;
    logic [XLEN-1:0] text_base_reg;
    logic [XLEN-1:0] r2_reg;

    logic              s_fire, s1_fire;
    logic [RIDX_W-1:0] ra_addr, rb_addr;
    logic [XLEN-1:0]   a_data, b_data;
    out_beat_t         res;
    wb_t               alu_wb, wb;

    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign s_fire  = s_valid && s_ready;

    // port a serves rs on execute and reg_index on register read
    assign ra_addr = (opcode_t'(s_beat.opcode) == OP_EXEC) ?
                     s_beat.instr_word[25:21] : s_beat.reg_index;
    assign rb_addr = s_beat.instr_word[20:16];

    assign wb.en   = alu_wb.en && s1_fire;
    assign wb.addr = alu_wb.addr;
    assign wb.data = alu_wb.data;

    mrex_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .ra_addr (ra_addr),
        .rb_addr (rb_addr),
        .wb      (wb),
        .a_data  (a_data),
        .b_data  (b_data)
    );

    mrex_alu u_alu (
        .beat      (s1_beat_reg),
        .a_data    (a_data),
        .b_data    (b_data),
        .r2_data   (r2_reg),
        .text_base (text_base_reg),
        .res       (res),
        .wb        (alu_wb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            text_base_reg <= TEXT_BASE_RST;
            r2_reg        <= '0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                text_base_reg <= cfg_wr_data;
            end
            if (wb.en && (wb.addr == SYSCALL_REG)) begin
                r2_reg <= wb.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_beat_reg <= s_beat;
        end
        if (s1_fire) begin
            m_beat_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

endmodule

`default_nettype wire

// ===== rtl/mrex_checker.sv =====
// mrex_checker: port-level assertions for the R-type execute unit, bound to
// the top level. Depends on mrex_pkg and mips_rtype_execute_unit_core.
`default_nettype none

module mrex_checker
    import mrex_pkg::*;
(
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire out_beat_t       m_beat
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_beat)))
        else $error("result beat changed while stalled");

    // a ready receiver never backs up the input
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is ready");

    // at most one status flag per result
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_beat.overflow, m_beat.unknown_function,
                              m_beat.jump_valid, m_beat.exit_request}))
        else $error("more than one status flag set");

    // the jump target only accompanies a jump
    a_target_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_beat.jump_valid) |-> (m_beat.jump_target == '0))
        else $error("jump target without jump");

    // an accepted beat is followed by a valid result beat
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##[1:2] m_valid)
        else $error("result beat missing");

endmodule

bind mips_rtype_execute_unit_core mrex_checker u_mrex_checker (.*);

`default_nettype wire
